// File: hw/rtl/drsc_pkg.sv
// Package for the debounced relay switch controller.
// Holds register indexes, item kinds, record and configuration types and reset constants.
// No dependencies.
package drsc_pkg;

  localparam int unsigned NumChannelsDef = 8;
  localparam int unsigned TimeBitsDef    = 32;
  localparam int unsigned ChanBits       = 3;
  localparam int unsigned TsBits         = 32;
  localparam int unsigned RegBits        = 8;
  localparam int unsigned RegIdxBits     = 2;
  localparam logic [RegBits-1:0] DebounceReset  = 8'd30;
  localparam logic [RegBits-1:0] ActiveLowReset = 8'hFF;
  localparam logic [RegBits-1:0] MomentaryReset = 8'h00;
  localparam logic [RegBits-1:0] ManualEnReset  = 8'hFF;

  typedef enum logic [RegIdxBits-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_ACTIVE_LO = 2'd1,
    REG_MOMENTARY = 2'd2,
    REG_MANUAL_EN = 2'd3
  } drsc_reg_e;

  typedef enum logic {
    FUNC_SAMPLE  = 1'b0,
    FUNC_COMMAND = 1'b1
  } drsc_func_e;

  typedef struct packed {
    logic [RegBits-1:0] debounce_ms;
    logic [RegBits-1:0] active_low_mask;
    logic [RegBits-1:0] momentary_mask;
    logic [RegBits-1:0] manual_enable_mask;
  } drsc_cfg_t;

  typedef struct packed {
    logic last_raw;
    logic stable;
    logic last_active;
    logic relay;
    logic ovr;
  } drsc_flags_t;

  localparam drsc_flags_t FlagsReset = '{
    last_raw: 1'b1, stable: 1'b1, last_active: 1'b0, relay: 1'b0, ovr: 1'b0
  };

endpackage

// File: hw/rtl/debounced_relay_switch_control_core.sv
// Top level of the debounced relay switch controller: stream ports, configuration
// registers, the channel record memory with forwarding, and the output register.
// Depends on drsc_pkg and drsc_update.
//
// Each transfer is either a pin sample or a remote relay command for one channel and
// yields exactly one result transfer. The block takes one transfer per cycle while the
// input is not held off. The channel record is read from the record memory into a
// register at the input transfer, beside the update stage registers; the update logic is
// combinational and its result is captured in the output register, which offers it. The
// input is held off only while both the update stage and the output register hold a
// transfer and the master side is not ready. The record written back is forwarded to a
// following transfer on the same channel, and per-entry valid bits give the reset record,
// so no clearing pass is needed after reset.
// Configuration should only be written while no transfer is in flight.
module debounced_relay_switch_control_core #(
  parameter int unsigned NUM_CHANNELS = drsc_pkg::NumChannelsDef,
  parameter int unsigned TIME_BITS    = drsc_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // channel[2:0], pin_level[3], requested_on[4], now_ms[36:5], zero fill
  input  logic [39:0]                   s_axis_tdata,
  // func
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_channel[2:0], relay_on[3], changed[4], manual_override[5], zero fill
  output logic [7:0]                    m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [drsc_pkg::RegIdxBits-1:0] cfg_index_i,
  input  logic [drsc_pkg::RegBits-1:0]  cfg_data_i
);
  import drsc_pkg::*;

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned RecW = TIME_BITS + $bits(drsc_flags_t);

  drsc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms        <= DebounceReset;
      cfg_q.active_low_mask    <= ActiveLowReset;
      cfg_q.momentary_mask     <= MomentaryReset;
      cfg_q.manual_enable_mask <= ManualEnReset;
    end else if (cfg_we_i) begin
      case (drsc_reg_e'(cfg_index_i))
        REG_DEBOUNCE:  cfg_q.debounce_ms        <= cfg_data_i;
        REG_ACTIVE_LO: cfg_q.active_low_mask    <= cfg_data_i;
        REG_MOMENTARY: cfg_q.momentary_mask     <= cfg_data_i;
        REG_MANUAL_EN: cfg_q.manual_enable_mask <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [ChanBits-1:0] in_chan;
  logic [7:0]          in_chan_w;
  logic [IdxW-1:0]     in_idx;
  logic                in_range;
  logic [63:0]         in_now_w;
  logic                in_acc;

  assign in_chan   = s_axis_tdata[2:0];
  assign in_chan_w = {5'b0, in_chan};
  assign in_idx    = in_chan_w[IdxW-1:0];
  assign in_range  = 32'(in_chan) < NUM_CHANNELS;
  assign in_now_w  = {32'b0, s_axis_tdata[36:5]};
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  logic                 s1_vld_q;
  logic [ChanBits-1:0]  s1_chan_q;
  logic [IdxW-1:0]      s1_idx_q;
  logic                 s1_range_q;
  logic                 s1_func_q;
  logic                 s1_raw_q;
  logic                 s1_req_q;
  logic [TIME_BITS-1:0] s1_now_q;
  logic                 s1_adv;

  logic       out_vld_q;
  logic [7:0] out_data_q;
  logic       out_free;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s1_adv        = s1_vld_q && out_free;
  assign s_axis_tready = !s1_vld_q || out_free;

  logic [RecW-1:0]         mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  logic [RecW-1:0]         rd_q;
  logic                    rd_vld_q;
  logic                    mem_we;
  logic [RecW-1:0]         mem_wd;

  logic                 fwd_vld_q;
  logic [IdxW-1:0]      fwd_idx_q;
  logic [RecW-1:0]      fwd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      rd_q <= mem[in_idx];
    end
    if (mem_we) begin
      mem[s1_idx_q] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_vld_q <= in_range ? vld_q[in_idx] : 1'b0;
      end
      if (mem_we) begin
        vld_q[s1_idx_q] <= 1'b1;
        fwd_vld_q       <= 1'b1;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_chan_q  <= in_chan;
      s1_idx_q   <= in_idx;
      s1_range_q <= in_range;
      s1_func_q  <= s_axis_tuser;
      s1_raw_q   <= s_axis_tdata[3];
      s1_req_q   <= s_axis_tdata[4];
      s1_now_q   <= in_now_w[TIME_BITS-1:0];
    end
    if (mem_we) begin
      fwd_idx_q <= s1_idx_q;
      fwd_q     <= mem_wd;
    end
  end

  logic [RecW-1:0]      cur_rec;
  drsc_flags_t          cur_flags;
  logic [TIME_BITS-1:0] cur_ct;
  drsc_flags_t          new_flags;
  logic [TIME_BITS-1:0] new_ct;
  logic                 issued;
  logic                 upd_wr;

  always_comb begin
    if (fwd_vld_q && (fwd_idx_q == s1_idx_q)) begin
      cur_rec = fwd_q;
    end else if (rd_vld_q) begin
      cur_rec = rd_q;
    end else begin
      cur_rec = {{TIME_BITS{1'b0}}, FlagsReset};
    end
  end

  assign cur_flags = drsc_flags_t'(cur_rec[$bits(drsc_flags_t)-1:0]);
  assign cur_ct    = cur_rec[RecW-1:$bits(drsc_flags_t)];

  drsc_update #(
    .TIME_BITS(TIME_BITS)
  ) u_update (
    .cfg_i   (cfg_q),
    .chan_i  (s1_chan_q),
    .func_i  (s1_func_q),
    .raw_i   (s1_raw_q),
    .req_i   (s1_req_q),
    .now_i   (s1_now_q),
    .flags_i (cur_flags),
    .ct_i    (cur_ct),
    .flags_o (new_flags),
    .ct_o    (new_ct),
    .issued_o(issued),
    .wr_o    (upd_wr)
  );

  assign mem_we = s1_adv && s1_range_q && upd_wr;
  assign mem_wd = {new_ct, new_flags};

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_range_q) begin
        out_data_q <= {2'b0, new_flags.ovr, issued, new_flags.relay, s1_chan_q};
      end else begin
        out_data_q <= {5'b0, s1_chan_q};
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_wr_only_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (s1_vld_q && out_free && s1_range_q))
    else $error("record written back without a result leaving the update stage");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_adv) |=> (s1_vld_q && $stable(s1_chan_q) && $stable(s1_func_q)))
    else $error("stalled update stage lost or changed its transfer");

  a_block_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_vld_q && out_vld_q && !m_axis_tready))
    else $error("input blocked while the pipeline had room");

  a_cmd_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_range_q && (drsc_func_e'(s1_func_q) == FUNC_COMMAND))
      |=> (m_axis_tdata[4] && (m_axis_tdata[3] == $past(s1_req_q))))
    else $error("remote command result does not report the requested relay state");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_range_q) |=> (m_axis_tdata[5:3] == 3'b000))
    else $error("result for an absent channel carries non-zero flags");

endmodule

// File: hw/rtl/drsc_update.sv
// Next-state logic for one channel record: remote commands, debounce, polarity and relay modes.
// Depends on drsc_pkg.
module drsc_update #(
  parameter int unsigned TIME_BITS = drsc_pkg::TimeBitsDef
) (
  input  drsc_pkg::drsc_cfg_t            cfg_i,
  input  logic [drsc_pkg::ChanBits-1:0]  chan_i,
  input  logic                           func_i,
  input  logic                           raw_i,
  input  logic                           req_i,
  input  logic [TIME_BITS-1:0]           now_i,
  input  drsc_pkg::drsc_flags_t          flags_i,
  input  logic [TIME_BITS-1:0]           ct_i,
  output drsc_pkg::drsc_flags_t          flags_o,
  output logic [TIME_BITS-1:0]           ct_o,
  output logic                           issued_o,
  output logic                           wr_o
);
  import drsc_pkg::*;

  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] deb_ext;
  logic                 active;

  assign deb_ext = {{(TIME_BITS-RegBits){1'b0}}, cfg_i.debounce_ms};

  always_comb begin
    flags_o  = flags_i;
    ct_o     = ct_i;
    issued_o = 1'b0;
    wr_o     = 1'b0;
    elapsed  = '0;
    active   = 1'b0;
    if (drsc_func_e'(func_i) == FUNC_COMMAND) begin
      flags_o.relay = req_i;
      issued_o      = 1'b1;
      wr_o          = 1'b1;
    end else if (cfg_i.manual_enable_mask[chan_i]) begin
      wr_o = 1'b1;
      if (raw_i != flags_i.last_raw) begin
        flags_o.last_raw = raw_i;
        ct_o             = now_i;
      end
      elapsed = now_i - ct_o;
      if ((raw_i != flags_i.stable) && (elapsed >= deb_ext)) begin
        flags_o.stable = raw_i;
        active = cfg_i.active_low_mask[chan_i] ? !raw_i : raw_i;
        if (cfg_i.momentary_mask[chan_i]) begin
          if (active && !flags_i.last_active) begin
            flags_o.relay = !flags_i.relay;
            flags_o.ovr   = 1'b1;
            issued_o      = 1'b1;
          end
        end else if (active != flags_i.relay) begin
          flags_o.relay = active;
          flags_o.ovr   = 1'b1;
          issued_o      = 1'b1;
        end
        flags_o.last_active = active;
      end
    end
  end

endmodule
